/* hw/rtl/pirt_pkg.sv */
// Package for the point-in-ring test unit: coordinate width, register
// indexes and the request structs of the vertex and result channels.
// Depends on nothing.
package pirt_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
	localparam int CROSS_WIDTH = PROD_WIDTH + 1;
	localparam int CFG_IDX_WIDTH = 3;
	localparam int CNT_WIDTH = 3;
	localparam logic [CNT_WIDTH-1:0] MIN_RING_VERTICES = 3'd4;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_TEST_X     = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_TEST_Y     = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_TEST_Z     = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_FILTER = 3'd3;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [CROSS_WIDTH-1:0] cross_t;

	typedef struct packed {
		coord_t vertex_x;
		coord_t vertex_y;
		coord_t vertex_z;
		logic   last_vertex;
	} vertex_t;

	typedef struct packed {
		logic inside_res;
		logic on_boundary;
	} result_t;

endpackage

/* hw/rtl/point_in_ring_test_unit.sv */
// Top level of the point-in-ring test unit: three-stage vertex pipeline,
// ring state and result register.
// Depends on pirt_pkg.
//
// Usage: write the test point (indexes 0..2) and the box-filter bit (index 3)
// on the cfg channel while the unit is idle; cfg_ready is always high and
// writes to indexes above 3 are dropped. Then stream the ring's vertices on
// the in channel, one request per vertex, the final one with last_vertex set.
// Each vertex after a ring's first closes the edge from the previous vertex.
// Throughput: one vertex per cycle while in_ready is high. Stage 1 forms
// differences against the point, stage 2 runs the two 33x33 cross-product
// multiplies, stage 3 takes the difference of the products and updates
// parity and boundary flags. The result request is registered from stage 3
// on the last vertex; a vertex that is not the last produces nothing on out.
// Stall: the result sits in the output register until taken. Vertices keep
// flowing meanwhile; only a further last vertex reaching stage 3 holds the
// pipeline, and in_ready drops until the waiting result is taken.
// Reset: clears the config registers, the pipeline valid bits, the vertex
// count and the parity and boundary flags; the next vertex starts a new ring.
module point_in_ring_test_unit
	import pirt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  vertex_t                  in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output result_t                  out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0]   cfg_data
);

	// configuration
	coord_t test_x_q, test_y_q, test_z_q;
	logic   box_filter_q;

	// ring state
	vertex_t               prev_q;
	logic [CNT_WIDTH-1:0]  cnt_q;
	coord_t                box_min_q [3];
	coord_t                box_max_q [3];
	logic                  parity_q;
	logic                  coll_q;

	// pipeline
	logic    en;
	logic    v_s1, v_s2, v_s3;
	vertex_t vtx_s1;
	diff_t   x1_s2, y1_s2, x2_s2, y2_s2;
	logic    first_s2, last_s2, dup_s2, strad_s2, dypos_s2, enough_s2;
	prod_t   p1_s3, p2_s3;
	logic    first_s3, last_s3, dup_s3, strad_s3, dypos_s3, enough_s3, boxok_s3;
	logic    out_valid_q;
	result_t out_q;

	// stage 1 combinational
	diff_t                x1, y1, x2, y2;
	logic                 first, dup, strad, dy_pos, enough;
	logic [CNT_WIDTH-1:0] cnt_inc;
	coord_t               vc [3];

	// stage 2 / 3 combinational
	logic   box_ok;
	prod_t  p1, p2;
	cross_t cr;
	logic   cr_zero, flip, coll_set, par_new, coll_new, inside_now, bound;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_x_q     <= '0;
			test_y_q     <= '0;
			test_z_q     <= '0;
			box_filter_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEST_X:     test_x_q     <= cfg_data;
				REG_TEST_Y:     test_y_q     <= cfg_data;
				REG_TEST_Z:     test_z_q     <= cfg_data;
				REG_BOX_FILTER: box_filter_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// only a second result waiting behind a full output register holds the pipe
	assign en        = !(v_s3 && last_s3 && out_valid_q && !out_ready);
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// ---------------- stage 1: differences, flags, box and count
	always_comb begin
		first   = (cnt_q == '0);
		x1      = {vtx_s1.vertex_x[COORD_WIDTH-1], vtx_s1.vertex_x}
			- {test_x_q[COORD_WIDTH-1], test_x_q};
		y1      = {vtx_s1.vertex_y[COORD_WIDTH-1], vtx_s1.vertex_y}
			- {test_y_q[COORD_WIDTH-1], test_y_q};
		x2      = {prev_q.vertex_x[COORD_WIDTH-1], prev_q.vertex_x}
			- {test_x_q[COORD_WIDTH-1], test_x_q};
		y2      = {prev_q.vertex_y[COORD_WIDTH-1], prev_q.vertex_y}
			- {test_y_q[COORD_WIDTH-1], test_y_q};
		dup     = (vtx_s1.vertex_x == prev_q.vertex_x) && (vtx_s1.vertex_y == prev_q.vertex_y)
			&& (vtx_s1.vertex_z == prev_q.vertex_z);
		strad   = (y1 > 0 && y2 <= 0) || (y2 > 0 && y1 <= 0);
		dy_pos  = (y2 > y1);
		cnt_inc = (cnt_q < MIN_RING_VERTICES) ? cnt_q + 1'b1 : cnt_q;
		enough  = (cnt_inc >= MIN_RING_VERTICES);
		vc[0]   = vtx_s1.vertex_x;
		vc[1]   = vtx_s1.vertex_y;
		vc[2]   = vtx_s1.vertex_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (en && v_s1) begin
			cnt_q <= vtx_s1.last_vertex ? '0 : cnt_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vtx_s1 <= in_data;
		end
		if (en && v_s1) begin
			prev_q <= vtx_s1;
			for (int i = 0; i < 3; i++) begin
				if (first || vc[i] < box_min_q[i]) begin
					box_min_q[i] <= vc[i];
				end
				if (first || vc[i] > box_max_q[i]) begin
					box_max_q[i] <= vc[i];
				end
			end
		end
		if (en) begin
			x1_s2     <= x1;
			y1_s2     <= y1;
			x2_s2     <= x2;
			y2_s2     <= y2;
			first_s2  <= first;
			last_s2   <= vtx_s1.last_vertex;
			dup_s2    <= dup;
			strad_s2  <= strad;
			dypos_s2  <= dy_pos;
			enough_s2 <= enough;
		end
	end

	// ---------------- stage 2: cross-product multiplies, box check
	// box registers already hold this item's ring box: later items are still behind it
	always_comb begin
		box_ok = (test_x_q >= box_min_q[0]) && (test_x_q <= box_max_q[0])
			&& (test_y_q >= box_min_q[1]) && (test_y_q <= box_max_q[1])
			&& (test_z_q >= box_min_q[2]) && (test_z_q <= box_max_q[2]);
		p1 = prod_t'(x1_s2) * prod_t'(y2_s2);
		p2 = prod_t'(x2_s2) * prod_t'(y1_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s3     <= p1;
			p2_s3     <= p2;
			first_s3  <= first_s2;
			last_s3   <= last_s2;
			dup_s3    <= dup_s2;
			strad_s3  <= strad_s2;
			dypos_s3  <= dypos_s2;
			enough_s3 <= enough_s2;
			boxok_s3  <= box_ok;
		end
	end

	// ---------------- stage 3: cross sign, parity, boundary, result
	always_comb begin
		cr         = {p1_s3[PROD_WIDTH-1], p1_s3} - {p2_s3[PROD_WIDTH-1], p2_s3};
		cr_zero    = (cr == '0);
		// sign of the cross product against sign of dy replaces the divide
		flip       = !first_s3 && strad_s3 && !cr_zero && (cr[CROSS_WIDTH-1] != dypos_s3);
		coll_set   = !first_s3 && !dup_s3 && cr_zero;
		par_new    = parity_q ^ flip;
		coll_new   = coll_q | coll_set;
		inside_now = enough_s3 && par_new && (!box_filter_q || boxok_s3);
		bound      = enough_s3 && coll_new && boxok_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q    <= 1'b0;
			coll_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en && v_s3) begin
				parity_q <= last_s3 ? 1'b0 : par_new;
				coll_q   <= last_s3 ? 1'b0 : coll_new;
			end
			if (en && v_s3 && last_s3) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s3 && last_s3) begin
			out_q.inside_res  <= inside_now;
			out_q.on_boundary <= bound;
		end
	end

	// ---------------- checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s3 && last_s3 && out_valid_q))
		else $error("pipeline held without a waiting result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s3 && last_s3 && en))
		else $error("result raised without a last vertex");

	a_ring_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s1 && vtx_s1.last_vertex) |=> (cnt_q == '0))
		else $error("vertex count not cleared at end of ring");

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MIN_RING_VERTICES)
		else $error("vertex count beyond saturation");

	a_flags_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s3 && last_s3) |=> (!parity_q && !coll_q))
		else $error("ring flags not cleared after result");

endmodule

/* verif/pirt_checker.sv */
// Checker for the point-in-ring test unit: watches the cfg, vertex and
// result channels, predicts each ring verdict and compares it.
// Depends on pirt_pkg.
module pirt_checker
	import pirt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  vertex_t                  in_data,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  result_t                  out_data,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0]   cfg_data,
	output int                       mismatch_count,
	output int                       verdicts_pending
);

	coord_t               pt_x, pt_y, pt_z;
	logic                 box_gate;
	coord_t               last_x, last_y, last_z;
	logic                 parity;
	logic                 touch;
	logic [CNT_WIDTH-1:0] seen;
	coord_t               lo [3];
	coord_t               hi [3];
	result_t              verdicts_due [$];

	function automatic logic point_in_box();
		return pt_x >= lo[0] && pt_x <= hi[0] &&
			pt_y >= lo[1] && pt_y <= hi[1] &&
			pt_z >= lo[2] && pt_z <= hi[2];
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	// One vertex request: close the edge from the previous vertex, grow the box,
	// and on the last vertex queue the ring verdict.
	task automatic absorb_vertex(input vertex_t v);
		diff_t   dx_now, dy_now, dx_was, dy_was;
		cross_t  cr;
		logic    straddle, rising;
		coord_t  c [3];
		result_t verdict;
		c[0] = v.vertex_x;
		c[1] = v.vertex_y;
		c[2] = v.vertex_z;
		if (seen == '0) begin
			for (int i = 0; i < 3; i++) begin
				lo[i] = c[i];
				hi[i] = c[i];
			end
		end else begin
			dx_now = v.vertex_x - pt_x;
			dy_now = v.vertex_y - pt_y;
			dx_was = last_x - pt_x;
			dy_was = last_y - pt_y;
			// exact: operands sign-extend to the full cross width first
			cr = dx_now * dy_was - dx_was * dy_now;
			straddle = (dy_now > 0 && dy_was <= 0) || (dy_was > 0 && dy_now <= 0);
			rising = dy_was > dy_now;
			if (straddle && cr != 0 && ((cr < 0) != rising)) begin
				parity = ~parity;
			end
			if (!(v.vertex_x == last_x && v.vertex_y == last_y && v.vertex_z == last_z)
				&& cr == 0) begin
				touch = 1'b1;
			end
			for (int i = 0; i < 3; i++) begin
				if (c[i] < lo[i]) lo[i] = c[i];
				if (c[i] > hi[i]) hi[i] = c[i];
			end
		end
		if (seen < MIN_RING_VERTICES) seen++;
		last_x = v.vertex_x;
		last_y = v.vertex_y;
		last_z = v.vertex_z;
		if (v.last_vertex) begin
			verdict.inside_res = seen >= MIN_RING_VERTICES && parity &&
				(!box_gate || point_in_box());
			verdict.on_boundary = seen >= MIN_RING_VERTICES && touch && point_in_box();
			verdicts_due.push_back(verdict);
			parity = 1'b0;
			touch = 1'b0;
			seen = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			pt_x = '0;
			pt_y = '0;
			pt_z = '0;
			box_gate = 1'b0;
			last_x = '0;
			last_y = '0;
			last_z = '0;
			parity = 1'b0;
			touch = 1'b0;
			seen = '0;
			for (int i = 0; i < 3; i++) begin
				lo[i] = '0;
				hi[i] = '0;
			end
			verdicts_due.delete();
			mismatch_count = 0;
			verdicts_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					note_mismatch($sformatf("result %b with none due", out_data));
				end else begin
					want = verdicts_due.pop_front();
					if (out_data.inside_res !== want.inside_res) begin
						note_mismatch($sformatf("inside_res expected %b got %b",
							want.inside_res, out_data.inside_res));
					end
					if (out_data.on_boundary !== want.on_boundary) begin
						note_mismatch($sformatf("on_boundary expected %b got %b",
							want.on_boundary, out_data.on_boundary));
					end
				end
			end
			if (in_valid && in_ready) begin
				absorb_vertex(in_data);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEST_X:     pt_x = cfg_data;
					REG_TEST_Y:     pt_y = cfg_data;
					REG_TEST_Z:     pt_z = cfg_data;
					REG_BOX_FILTER: box_gate = cfg_data[0];
					default: ;
				endcase
			end
			verdicts_pending = verdicts_due.size();
		end
	end

endmodule

/* verif/testbench.sv */
// Top of the point-in-ring test unit bench: clock, reset, register writes,
// vertex stimulus and random output stalls; verdict from pirt_checker.
// Depends on pirt_pkg, pirt_checker and point_in_ring_test_unit.
module testbench;
	import pirt_pkg::*;

	localparam int     CYCLE_LIMIT     = 400000;
	localparam int     PHASES          = 9;
	localparam int     ITEMS_PER_PHASE = 190;
	localparam coord_t CMAX            = 32'sh7fffffff;
	localparam coord_t CMIN            = 32'sh80000000;

	typedef enum {SPREAD_NEAR, SPREAD_WIDE, SPREAD_EXTREME} spread_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	vertex_t                  in_data;
	logic                     out_valid;
	logic                     out_ready;
	result_t                  out_data;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	logic [COORD_WIDTH-1:0]   cfg_data;
	int                       mismatch_count;
	int                       verdicts_pending;

	int      cycle_count = 0;
	int      sent = 0;
	bit      gaps_on = 1'b0;
	bit      stalls_on = 1'b0;
	coord_t  tx, ty, tz;
	vertex_t prev_sent;

	point_in_ring_test_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pirt_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_data          (in_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_data         (out_data),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatch_count   (mismatch_count),
		.verdicts_pending (verdicts_pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random stall bursts while enabled
	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (stalls_on && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_ready = 1'b1;
			end
		end
	end

	// all tasks below start and end at a falling edge
	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
		input logic [COORD_WIDTH-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_point(input coord_t x, input coord_t y, input coord_t z,
		input logic gate);
		write_reg(REG_TEST_X, x);
		write_reg(REG_TEST_Y, y);
		write_reg(REG_TEST_Z, z);
		write_reg(REG_BOX_FILTER, {$urandom} << 1 | gate);
		// indexes past the last register must be dropped
		if ($urandom_range(0, 1))
			write_reg(CFG_IDX_WIDTH'(REG_BOX_FILTER + 1 + $urandom_range(0, 3)), $urandom);
		cfg_valid = 1'b0;
		tx = x;
		ty = y;
		tz = z;
	endtask

	task automatic push_vertex(input vertex_t v);
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = v;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		prev_sent = v;
		sent++;
	endtask

	// hold off until every verdict has come and the pipeline has emptied
	task automatic settle();
		in_valid = 1'b0;
		while (verdicts_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic vertex_t mk(input int x, input int y, input int z, input logic last);
		vertex_t v;
		v.vertex_x = x;
		v.vertex_y = y;
		v.vertex_z = z;
		v.last_vertex = last;
		return v;
	endfunction

	function automatic coord_t spread_coord(input spread_t s, input coord_t center);
		case (s)
			SPREAD_NEAR: return center + coord_t'($urandom_range(0, 8)) - coord_t'(4);
			SPREAD_WIDE: return coord_t'($urandom);
			default: begin
				case ($urandom_range(0, 5))
					0:       return CMIN;
					1:       return CMAX;
					2:       return '0;
					3:       return '1;
					4:       return center;
					default: return center + coord_t'(1);
				endcase
			end
		endcase
	endfunction

	function automatic vertex_t pick_vertex(input spread_t s, input logic last);
		vertex_t v;
		if ($urandom_range(0, 9) == 0) begin
			v = prev_sent;
		end else begin
			v.vertex_x = spread_coord(s, tx);
			v.vertex_y = spread_coord(s, ty);
			v.vertex_z = spread_coord($urandom_range(0, 5) == 0 ? SPREAD_WIDE : s, tz);
		end
		v.last_vertex = last;
		return v;
	endfunction

	task automatic send_ring();
		int      n;
		int      pick;
		spread_t s;
		pick = $urandom_range(0, 19);
		if (pick < 2) n = $urandom_range(1, 3);
		else if (pick == 2) n = $urandom_range(10, 24);
		else n = $urandom_range(4, 9);
		pick = $urandom_range(0, 19);
		s = pick < 13 ? SPREAD_NEAR : pick < 17 ? SPREAD_WIDE : SPREAD_EXTREME;
		for (int k = 0; k < n; k++) begin
			push_vertex(pick_vertex(s, k == n - 1));
		end
	endtask

	initial begin
		int phase_end;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx = '0;
		ty = '0;
		tz = '0;
		prev_sent = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed rings, registers at reset values first
		push_vertex(mk(5, 5, 5, 1'b1));
		push_vertex(mk(-1, -1, 0, 1'b0));
		push_vertex(mk(1, -1, 0, 1'b0));
		push_vertex(mk(1, 1, 0, 1'b1));
		push_vertex(mk(-2, -2, 0, 1'b0));
		push_vertex(mk(2, -2, 0, 1'b0));
		push_vertex(mk(2, 2, 0, 1'b0));
		push_vertex(mk(-2, 2, 0, 1'b1));
		// repeated vertex, then an edge through the point
		push_vertex(mk(0, -3, 0, 1'b0));
		push_vertex(mk(0, -3, 0, 1'b0));
		push_vertex(mk(0, 3, 0, 1'b0));
		push_vertex(mk(4, 3, 0, 1'b1));
		settle();
		set_point(CMAX, CMIN, '0, 1'b1);
		push_vertex(mk(CMIN, CMIN, CMIN, 1'b0));
		push_vertex(mk(CMAX, CMIN, CMAX, 1'b0));
		push_vertex(mk(CMAX, CMAX, 0, 1'b0));
		push_vertex(mk(CMIN, CMAX, -1, 1'b0));
		push_vertex(mk(CMIN, CMIN, CMIN, 1'b1));
		settle();
		set_point(1, 1, 1, 1'b1);
		push_vertex(mk(0, 0, 0, 1'b0));
		push_vertex(mk(3, 0, 2, 1'b0));
		push_vertex(mk(3, 3, 2, 1'b0));
		push_vertex(mk(0, 3, 0, 1'b1));
		// same ring, box misses the point in z
		push_vertex(mk(0, 0, 5, 1'b0));
		push_vertex(mk(3, 0, 5, 1'b0));
		push_vertex(mk(3, 3, 5, 1'b0));
		push_vertex(mk(0, 3, 5, 1'b1));

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			gaps_on = ph < PHASES - 2 && ph != 3;
			stalls_on = ph < PHASES - 2 && ph != 4;
			case (ph)
				0: set_point('0, '0, '0, 1'b0);
				1: set_point(CMAX, CMAX, CMAX, 1'b1);
				2: set_point(CMIN, CMIN, CMIN, 1'b0);
				default: begin
					if ($urandom_range(0, 1))
						set_point($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
					else
						set_point($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
							$urandom_range(0, 40) - 20, 1'($urandom_range(0, 1)));
				end
			endcase
			phase_end = sent + ITEMS_PER_PHASE;
			while (sent < phase_end) send_ring();
		end

		in_valid = 1'b0;
		while (verdicts_pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && verdicts_pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
